// ===== rtl/sgo_pkg.sv =====
package sgo_pkg;

  localparam int MAX_WIDTH       = 1024;
  localparam int ADDR_W          = $clog2(MAX_WIDTH);
  localparam int COL_W           = 10;
  localparam int ROW_W           = 13;
  localparam int OUT_ROW_W       = 12;
  localparam int LUM_W           = 15;
  localparam int SUM_W           = 20;
  localparam int ANG_W           = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int CORDIC_STEPS    = 31;
  localparam int STEP_W          = 5;
  localparam int TAB_FRAC        = 30;
  localparam int XY_W            = 56;
  localparam int Z_W             = 35;
  localparam int QDEPTH          = 4;
  localparam int QPTR_W          = 2;
  localparam int QCNT_W          = 3;

  localparam logic signed [Z_W-1:0] PI_Q30 = 35'sd3373259426;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef logic [LUM_W-1:0] lum_t;

  typedef struct packed {
    lum_t top;
    lum_t mid;
    lum_t bot;
  } wcol_t;

  typedef struct packed {
    logic [COL_W-1:0]     column;
    logic [OUT_ROW_W-1:0] row;
    logic signed [SUM_W-1:0] vsum;
    logic signed [SUM_W-1:0] hsum;
    logic                 last;
  } job_t;

  typedef enum logic [1:0] {FR_IDLE, FR_CALC, FR_EMIT2} fr_state_t;
  typedef enum logic [1:0] {BK_IDLE, BK_RUN, BK_OUT} bk_state_t;

  function automatic logic signed [SUM_W:0] ext(input lum_t a);
    ext = $signed({{(SUM_W+1-LUM_W){1'b0}}, a});
  endfunction

  function automatic logic signed [SUM_W-1:0] vert_sum(input wcol_t l, input wcol_t c,
                                                       input wcol_t r);
    logic signed [SUM_W:0] t;
    t = 21'sd3 * (ext(l.top) - ext(l.bot)) + 21'sd10 * (ext(c.top) - ext(c.bot))
      + 21'sd3 * (ext(r.top) - ext(r.bot));
    vert_sum = t[SUM_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] horz_sum(input wcol_t l, input wcol_t r);
    logic signed [SUM_W:0] t;
    t = 21'sd3 * (ext(l.top) - ext(r.top)) + 21'sd10 * (ext(l.mid) - ext(r.mid))
      + 21'sd3 * (ext(l.bot) - ext(r.bot));
    horz_sum = t[SUM_W-1:0];
  endfunction

  function automatic logic signed [Z_W-1:0] atan_q30(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0: v = 35'sd843314857;
      5'd1: v = 35'sd497837829;
      5'd2: v = 35'sd263043837;
      5'd3: v = 35'sd133525159;
      5'd4: v = 35'sd67021687;
      5'd5: v = 35'sd33543516;
      5'd6: v = 35'sd16775851;
      5'd7: v = 35'sd8388437;
      5'd8: v = 35'sd4194283;
      5'd9: v = 35'sd2097149;
      default: v = $signed(Z_W'(1) << (5'd30 - i));
    endcase
    atan_q30 = v;
  endfunction

endpackage

// ===== rtl/scharr_gradient_orientation.sv =====
// Scharr gradient orientation: RGB pixels arrive in raster order, one request per pixel
// (tuser = 1 marks a flush item standing in for the row below the last row). Each
// pixel becomes luminance 30R+59G+11B; two 1024-entry line stores and a 3x3 window
// give the Scharr sums and the angle atan2(vertical, horizontal) in Q3.13 radians.
// Up to two results per request, the final one flagged by out_tlast. The front end
// takes a new request only after it has finished the previous one and only while the
// queue has room for two results; the back end computes each angle with a 31-iteration
// CORDIC and takes a new job once the last result is in its output register. A 4-entry
// queue decouples the two. The line stores need no clearing pass; config is 1-bit index
// (0 width, 1 height) and is taken at any cycle, meant to be written while idle.
module scharr_gradient_orientation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // out_column[9:0], out_row[21:10], vertical_sum[41:22],
                                  // horizontal_sum[61:42], angle[77:62], zero[79:78]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  logic [10:0]   width_r;
  logic [12:0]   height_r;
  logic          push, room, q_valid, pop;
  sgo_pkg::job_t push_job, q_job, out_job;
  logic [sgo_pkg::ANG_W-1:0] angle;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd640;
      height_r <= 13'd480;
    end else if (cfg_valid) begin
      case (cfg_index)
        sgo_pkg::CFG_WIDTH:  width_r  <= cfg_data[10:0];
        sgo_pkg::CFG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  sgo_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .kind(in_tuser),
    .red(in_tdata[7:0]), .green(in_tdata[15:8]), .blue(in_tdata[23:16]),
    .image_width(width_r), .image_height(height_r),
    .q_room(room), .push(push), .push_job(push_job)
  );

  sgo_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_job(push_job), .room(room),
    .q_valid(q_valid), .pop(pop), .q_job(q_job)
  );

  sgo_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_job(q_job), .pop(pop),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_job(out_job), .out_angle(angle)
  );

  assign out_tdata = {2'b00, angle, out_job.hsum, out_job.vsum, out_job.row, out_job.column};
  assign out_tlast = out_job.last;

endmodule

// ===== rtl/sgo_ram.sv =====
module sgo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sgo_front.sv =====
module sgo_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       kind,
  input  logic [7:0]                 red,
  input  logic [7:0]                 green,
  input  logic [7:0]                 blue,
  input  logic [10:0]                image_width,
  input  logic [12:0]                image_height,
  input  logic                       q_room,
  output logic                       push,
  output sgo_pkg::job_t              push_job
);

  sgo_pkg::fr_state_t state_r, state_nxt;
  logic [sgo_pkg::COL_W-1:0] col_r, ecol_r;
  logic [sgo_pkg::ROW_W-1:0] row_r, erow_r;
  logic                      kind_r;
  sgo_pkg::lum_t             lum_r;
  sgo_pkg::wcol_t            w1_r, w2_r, newcol;
  sgo_pkg::lum_t             mid, top, bot;
  sgo_pkg::lum_t             top_raw;
  logic [10:0]               w_eff;
  logic [12:0]               h_eff;
  logic [sgo_pkg::COL_W-1:0] last_col;
  logic                      e1, e2, rok, we;
  logic [16:0]               lum_wide;
  sgo_pkg::wcol_t            jl, jc, jr;

  sgo_ram #(.WIDTH(sgo_pkg::LUM_W), .DEPTH(sgo_pkg::MAX_WIDTH)) u_ls0 (
    .clk(clk), .we(we), .waddr(col_r), .wdata(bot), .raddr(col_r), .rdata(mid)
  );
  sgo_ram #(.WIDTH(sgo_pkg::LUM_W), .DEPTH(sgo_pkg::MAX_WIDTH)) u_ls1 (
    .clk(clk), .we(we), .waddr(col_r), .wdata(mid), .raddr(col_r), .rdata(top_raw)
  );

  assign w_eff    = (image_width == 11'd0) ? 11'd1 :
                    (image_width > 11'(sgo_pkg::MAX_WIDTH)) ? 11'(sgo_pkg::MAX_WIDTH) :
                    image_width;
  assign h_eff    = (image_height == 13'd0) ? 13'd1 : image_height;
  assign last_col = sgo_pkg::COL_W'(w_eff - 11'd1);
  assign e1       = (col_r != '0);
  assign e2       = (col_r >= last_col);
  assign rok      = (row_r != '0);
  assign lum_wide = 17'd30 * 17'(red) + 17'd59 * 17'(green) + 17'd11 * 17'(blue);

  assign top    = (row_r >= 13'd2) ? top_raw : mid;
  assign bot    = kind_r ? mid : lum_r;
  assign newcol = '{top: top, mid: mid, bot: bot};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sgo_pkg::FR_IDLE:  if (in_valid && q_room) state_nxt = sgo_pkg::FR_CALC;
      sgo_pkg::FR_CALC:  state_nxt = (rok && e1 && e2) ? sgo_pkg::FR_EMIT2 : sgo_pkg::FR_IDLE;
      sgo_pkg::FR_EMIT2: state_nxt = sgo_pkg::FR_IDLE;
      default:           state_nxt = sgo_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    we       = 1'b0;
    push     = 1'b0;
    jl = newcol;
    jc = newcol;
    jr = newcol;
    push_job.column = col_r;
    push_job.row    = sgo_pkg::OUT_ROW_W'(row_r - 13'd1);
    push_job.last   = 1'b1;
    case (state_r)
      sgo_pkg::FR_IDLE: begin
        in_ready = q_room;
      end
      sgo_pkg::FR_CALC: begin
        we   = 1'b1;
        push = rok && (e1 || e2);
        if (e1) begin
          jl = (col_r >= 10'd2) ? w1_r : w2_r;
          jc = w2_r;
          push_job.column = col_r - 10'd1;
          push_job.last   = !e2;
        end
      end
      sgo_pkg::FR_EMIT2: begin
        push = 1'b1;
        jl = w1_r;
        jc = w2_r;
        jr = w2_r;
        push_job.column = ecol_r;
        push_job.row    = sgo_pkg::OUT_ROW_W'(erow_r - 13'd1);
      end
      default: ;
    endcase
    push_job.vsum = sgo_pkg::vert_sum(jl, jc, jr);
    push_job.hsum = sgo_pkg::horz_sum(jl, jr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sgo_pkg::FR_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      w1_r    <= '0;
      w2_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == sgo_pkg::FR_CALC) begin
        w1_r <= w2_r;
        w2_r <= newcol;
        if (e2) begin
          col_r <= '0;
          row_r <= (row_r >= h_eff) ? '0 : row_r + 13'd1;
        end else begin
          col_r <= col_r + 10'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r <= kind;
      lum_r  <= lum_wide[sgo_pkg::LUM_W-1:0];
    end
    if (state_r == sgo_pkg::FR_CALC) begin
      ecol_r <= col_r;
      erow_r <= row_r;
    end
  end

endmodule

// ===== rtl/sgo_queue.sv =====
module sgo_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sgo_pkg::job_t push_job,
  output logic          room,
  output logic          q_valid,
  input  logic          pop,
  output sgo_pkg::job_t q_job
);

  sgo_pkg::job_t                mem_r [sgo_pkg::QDEPTH];
  logic [sgo_pkg::QPTR_W-1:0]   wp_r, rp_r;
  logic [sgo_pkg::QCNT_W-1:0]   cnt_r;

  assign room    = (cnt_r <= sgo_pkg::QCNT_W'(sgo_pkg::QDEPTH - 2));
  assign q_valid = (cnt_r != '0);
  assign q_job   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + sgo_pkg::QCNT_W'(push) - sgo_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

endmodule

// ===== rtl/sgo_back.sv =====
module sgo_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  sgo_pkg::job_t q_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output sgo_pkg::job_t out_job,
  output logic [sgo_pkg::ANG_W-1:0] out_angle
);

  sgo_pkg::bk_state_t state_r, state_nxt;
  logic signed [sgo_pkg::XY_W-1:0] x_r, y_r, x0, y0, xs, ys;
  logic signed [sgo_pkg::Z_W-1:0]  z_r, zr, at;
  logic [sgo_pkg::STEP_W-1:0]      step_r;
  sgo_pkg::job_t                   job_r;
  logic                            zero_r, valid_r, load_out;

  assign x0 = {{(sgo_pkg::XY_W-sgo_pkg::SUM_W-32){q_job.hsum[sgo_pkg::SUM_W-1]}},
               q_job.hsum, 32'd0};
  assign y0 = {{(sgo_pkg::XY_W-sgo_pkg::SUM_W-32){q_job.vsum[sgo_pkg::SUM_W-1]}},
               q_job.vsum, 32'd0};
  assign xs = x_r >>> step_r;
  assign ys = y_r >>> step_r;
  assign at = sgo_pkg::atan_q30(step_r);
  assign zr = z_r + (sgo_pkg::Z_W'(1) << (sgo_pkg::TAB_FRAC - sgo_pkg::ANGLE_FRAC_BITS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sgo_pkg::BK_IDLE: if (q_valid) state_nxt = sgo_pkg::BK_RUN;
      sgo_pkg::BK_RUN:
        if (step_r == sgo_pkg::STEP_W'(sgo_pkg::CORDIC_STEPS - 1)) state_nxt = sgo_pkg::BK_OUT;
      sgo_pkg::BK_OUT:  if (!valid_r || out_ready) state_nxt = sgo_pkg::BK_IDLE;
      default:          state_nxt = sgo_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state_r)
      sgo_pkg::BK_IDLE: pop = q_valid;
      sgo_pkg::BK_OUT:  load_out = !valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sgo_pkg::BK_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) valid_r <= 1'b1;
      else if (out_ready) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r  <= q_job;
      zero_r <= (q_job.vsum == '0) && (q_job.hsum == '0);
      step_r <= '0;
      if (q_job.hsum[sgo_pkg::SUM_W-1]) begin
        x_r <= -x0;
        y_r <= -y0;
        z_r <= q_job.vsum[sgo_pkg::SUM_W-1] ? -sgo_pkg::PI_Q30 : sgo_pkg::PI_Q30;
      end else begin
        x_r <= x0;
        y_r <= y0;
        z_r <= '0;
      end
    end else if (state_r == sgo_pkg::BK_RUN) begin
      step_r <= step_r + 1'b1;
      if (y_r > 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end
    end
    if (load_out) begin
      out_job   <= job_r;
      out_angle <= zero_r ? '0 : zr[sgo_pkg::TAB_FRAC - sgo_pkg::ANGLE_FRAC_BITS +: sgo_pkg::ANG_W];
    end
  end

  assign out_valid = valid_r;

endmodule

// ===== rtl/sgo_checker.sv =====
module sgo_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);

  logic signed [15:0] ang;
  assign ang = out_tdata[77:62];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[41:22] == 20'd0 && out_tdata[61:42] == 20'd0 |-> ang == 16'sd0)
    else $error("zero vector gave nonzero angle");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ang <= 16'sd25736 && ang >= -16'sd25736)
    else $error("angle beyond pi");

  a_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[61] |-> ang <= 16'sd12868 && ang >= -16'sd12868)
    else $error("angle beyond pi/2 for nonnegative horizontal sum");

endmodule

bind scharr_gradient_orientation sgo_checker u_sgo_checker (.*);
